// ===== src/multi_stop_color_gradient_defines.svh =====
// assertion macros for the multi-stop color gradient checker
// no dependencies; included by the checker file only
`ifndef MULTI_STOP_COLOR_GRADIENT_DEFINES_SVH
`define MULTI_STOP_COLOR_GRADIENT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MSCG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mscg: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define MSCG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mscg: next-cycle check failed");

`endif

// ===== src/mscg_pkg.sv =====
// shared types and constants of the multi-stop color gradient block
// no dependencies; imported by every module of the block
package mscg_pkg;

  localparam int unsigned CH_W      = 8;   // one color channel
  localparam int unsigned NUM_CH    = 3;   // red, green, blue
  localparam int unsigned DATA_W    = 24;  // packed stream data
  localparam int unsigned CC_W      = 7;   // stops-per-gradient register
  localparam int unsigned SC_W      = 6;   // stop_count register
  localparam int unsigned N_W       = 6;   // steps per segment
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned DIV_N_W   = 8;   // divider dividend / quotient
  localparam int unsigned DIV_D_W   = 7;   // divider divisor / remainder
  localparam int unsigned DIV_CNT_W = 3;   // counts the 8 divider steps
  localparam int unsigned ACC_W     = 10;  // signed running color value

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;         // take the incoming stop
    logic div_start;    // launch the shared dividers
    logic div_sel_n;    // divide for the segment step count
    logic latch_n;      // store the step count
    logic init_iter;    // set up the per-channel step unit
    logic emit_step;    // push one interpolated color
    logic emit_final;   // push the closing stop color
    logic commit_stop;  // stop becomes previous, count it
    logic commit_end;   // gradient done, clear its state
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic first_stop;
    logic last_stop;
    logic n_zero;
    logic div_done;
    logic step_last;
    logic out_free;
  } sts_t;

endpackage

// ===== src/mscg_divider.sv =====
// restoring divider, one quotient bit per cycle
// depends on mscg_pkg
module mscg_divider
  import mscg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] dividend_i,
  input  logic [DIV_D_W-1:0] divisor_i,
  output logic               done_o,
  output logic [DIV_N_W-1:0] quot_o,
  output logic [DIV_D_W-1:0] rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_D_W-1:0]   rem_q, rem_d;
  logic [DIV_N_W-1:0]   quo_q, quo_d;
  logic [DIV_D_W-1:0]   dvs_q, dvs_d;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;
  logic                 fits;

  // one trial subtraction per cycle
  assign trial = {rem_q, quo_q[DIV_N_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      quo_d = {quo_q[DIV_N_W-2:0], fits};
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/mscg_ctrl.sv =====
// controller state machine for the gradient block
// depends on mscg_pkg; drives mscg_datapath through cmd_t
module mscg_ctrl
  import mscg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_WAIT_N,
    S_WAIT_C,
    S_EMIT,
    S_FINAL
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.first_stop) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel_n = 1'b1;
          state_d         = S_WAIT_N;
        end else if (sts_i.n_zero) begin
          if (sts_i.last_stop) begin
            state_d = S_FINAL;
          end else begin
            cmd_o.commit_stop = 1'b1;
            state_d           = S_IDLE;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_WAIT_C;
        end
      end
      S_WAIT_N: begin
        if (sts_i.div_done) begin
          cmd_o.latch_n     = 1'b1;
          cmd_o.commit_stop = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_WAIT_C: begin
        if (sts_i.div_done) begin
          cmd_o.init_iter = 1'b1;
          state_d         = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_step = 1'b1;
          if (sts_i.step_last) begin
            if (sts_i.last_stop) begin
              state_d = S_FINAL;
            end else begin
              cmd_o.commit_stop = 1'b1;
              state_d           = S_IDLE;
            end
          end
        end
      end
      S_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_final = 1'b1;
          cmd_o.commit_end = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== src/mscg_datapath.sv =====
// datapath: config registers, stop state, dividers, step unit, output register
// depends on mscg_pkg and mscg_divider
module mscg_datapath
  import mscg_pkg::*;
#(
  parameter int unsigned MAX_COLORS = 64,
  parameter int unsigned MAX_STEPS  = 63
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic [DATA_W-1:0]    in_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [DATA_W-1:0]    out_data_o,
  output logic                 out_last_o,
  output logic                 out_end_o,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o
);

  localparam logic [8:0]      MaxColors9 = 9'(MAX_COLORS);
  localparam logic [CC_W-1:0] MaxColors  = CC_W'(MAX_COLORS);
  localparam logic [SC_W-1:0] MaxSteps   = SC_W'(MAX_STEPS);

  logic [CC_W-1:0] cc_q, cc_d;
  logic [SC_W-1:0] sc_q, sc_d;
  logic [CC_W-1:0] eff_cc;
  logic [SC_W-1:0] eff_sc;

  logic [NUM_CH-1:0][CH_W-1:0]    prev_q, cur_q;
  logic [CC_W-1:0]                seen_q;
  logic [N_W-1:0]                 n_q;
  logic                           last_q;
  logic [N_W-1:0]                 j_q;
  logic [NUM_CH-1:0][ACC_W-1:0]   acc_q;
  logic [NUM_CH-1:0][DIV_D_W-1:0] r_q;
  logic [NUM_CH-1:0][ACC_W-1:0]   qd_q;
  logic [NUM_CH-1:0][DIV_D_W-1:0] rd_q;

  logic                           out_valid_q;
  logic [DATA_W-1:0]              out_data_q;
  logic                           out_last_q;
  logic                           out_end_q;

  logic [NUM_CH-1:0][DIV_N_W-1:0] div_a;
  logic [NUM_CH-1:0][DIV_D_W-1:0] div_b;
  logic [NUM_CH-1:0]              div_done;
  logic [NUM_CH-1:0][DIV_N_W-1:0] div_q;
  logic [NUM_CH-1:0][DIV_D_W-1:0] div_r;
  logic [NUM_CH-1:0]              neg;

  logic [DIV_D_W-1:0]             n2;
  logic [CC_W:0]                  seen_next;

  // config writes
  always_comb begin
    cc_d = cc_q;
    sc_d = sc_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COLOR_COUNT: cc_d = cfg_wdata_i[CC_W-1:0];
        REG_STOP_COUNT:  sc_d = cfg_wdata_i[SC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= CC_W'(2);
      sc_q <= SC_W'(2);
    end else begin
      cc_q <= cc_d;
      sc_q <= sc_d;
    end
  end

  // saturated register values
  always_comb begin
    if (cc_q < CC_W'(2)) begin
      eff_cc = CC_W'(2);
    end else if ({2'b00, cc_q} > MaxColors9) begin
      eff_cc = MaxColors;
    end else begin
      eff_cc = cc_q;
    end
    if (sc_q < SC_W'(2)) begin
      eff_sc = SC_W'(2);
    end else if (sc_q > MaxSteps) begin
      eff_sc = MaxSteps;
    end else begin
      eff_sc = sc_q;
    end
  end

  assign seen_next = {1'b0, seen_q} + (CC_W+1)'(1);
  assign n2        = {n_q, 1'b0};

  // divider lanes: lane 0 also finds the step count at a gradient's first stop
  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    assign neg[c] = cur_q[c] < prev_q[c];

    always_comb begin
      if (cmd_i.div_sel_n && c == 0) begin
        div_a[c] = {2'b00, eff_sc};
        div_b[c] = eff_cc - CC_W'(1);
      end else begin
        div_a[c] = neg[c] ? (prev_q[c] - cur_q[c]) : (cur_q[c] - prev_q[c]);
        div_b[c] = {1'b0, n_q};
      end
    end

    mscg_divider u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (cmd_i.div_start),
      .dividend_i (div_a[c]),
      .divisor_i  (div_b[c]),
      .done_o     (div_done[c]),
      .quot_o     (div_q[c]),
      .rem_o      (div_r[c])
    );
  end

  // per-channel step unit: value and remainder modulo 2N
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (cmd_i.init_iter) begin
        acc_q[c] <= {2'b00, prev_q[c]};
        r_q[c]   <= {1'b0, n_q};
        if (!neg[c]) begin
          qd_q[c] <= {2'b00, div_q[c]};
          rd_q[c] <= {div_r[c][N_W-1:0], 1'b0};
        end else if (div_r[c] == '0) begin
          qd_q[c] <= ACC_W'(0) - {2'b00, div_q[c]};
          rd_q[c] <= '0;
        end else begin
          qd_q[c] <= ACC_W'(0) - {2'b00, div_q[c]} - ACC_W'(1);
          rd_q[c] <= {n_q - div_r[c][N_W-1:0], 1'b0};
        end
      end else if (cmd_i.emit_step) begin
        if (({1'b0, r_q[c]} + {1'b0, rd_q[c]}) >= {1'b0, n2}) begin
          r_q[c]   <= DIV_D_W'({1'b0, r_q[c]} + {1'b0, rd_q[c]} - {1'b0, n2});
          acc_q[c] <= acc_q[c] + qd_q[c] + ACC_W'(1);
        end else begin
          r_q[c]   <= DIV_D_W'({1'b0, r_q[c]} + {1'b0, rd_q[c]});
          acc_q[c] <= acc_q[c] + qd_q[c];
        end
      end
    end
  end

  // stop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      cur_q  <= '0;
      seen_q <= '0;
      n_q    <= '0;
      last_q <= 1'b0;
      j_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        cur_q  <= in_data_i;
        last_q <= seen_next >= {1'b0, eff_cc};
      end
      if (cmd_i.latch_n) begin
        n_q <= div_q[0][N_W-1:0];
      end
      if (cmd_i.init_iter) begin
        j_q <= '0;
      end else if (cmd_i.emit_step) begin
        j_q <= j_q + N_W'(1);
      end
      if (cmd_i.commit_end) begin
        prev_q <= '0;
        seen_q <= '0;
      end else if (cmd_i.commit_stop) begin
        prev_q <= cur_q;
        seen_q <= seen_next[CC_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_step || cmd_i.emit_final) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_step) begin
      for (int c = 0; c < NUM_CH; c++) begin
        out_data_q[c*CH_W +: CH_W] <= acc_q[c][CH_W-1:0];
      end
      out_last_q <= !last_q && (j_q == n_q - N_W'(1));
      out_end_q  <= 1'b0;
    end else if (cmd_i.emit_final) begin
      out_data_q <= cur_q;
      out_last_q <= 1'b1;
      out_end_q  <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;
  assign out_end_o   = out_end_q;

  // status to the controller
  assign sts_o.first_stop = (seen_q == '0);
  assign sts_o.last_stop  = last_q;
  assign sts_o.n_zero     = (n_q == '0);
  assign sts_o.div_done   = div_done[0];
  assign sts_o.step_last  = (j_q == n_q - N_W'(1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ===== src/multi_stop_color_gradient.sv =====
// top level of the multi-stop color gradient generator
// depends on mscg_pkg, mscg_ctrl, mscg_datapath (and mscg_divider below it)
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+-------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | color stop r, g, b
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | color, run_last, gradient_end
//  cfg       | in        | cfg_we_i (no stall)          | stops per gradient, total steps
//
// a gradient's first stop runs the 8-step shared divider to find N; a later stop runs 8
// divider steps per channel (none when N is zero), then one color per cycle while m_axis
// is free, from the incremental step unit; the closing stop adds its own color
// a new stop is taken only when the previous one has issued all its colors
// the output register keeps one color; a stall on m_axis holds the step unit
// reset (rst_ni, async, active low) clears control state and sets both registers to 2
module multi_stop_color_gradient
  import mscg_pkg::*;
#(
  parameter int unsigned MAX_COLORS = 64,
  parameter int unsigned MAX_STEPS  = 63
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // incoming color stops
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DATA_W-1:0]    s_axis_tdata,   // in_red, in_green, in_blue
  // emitted gradient colors
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DATA_W-1:0]    m_axis_tdata,   // out_red, out_green, out_blue
  output logic                 m_axis_tlast,   // run_last
  output logic                 m_axis_tuser    // gradient_end
);

  cmd_t cmd;
  sts_t sts;

  mscg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mscg_datapath #(
    .MAX_COLORS (MAX_COLORS),
    .MAX_STEPS  (MAX_STEPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_end_o   (m_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== src/mscg_checker.sv =====
// port-level checks for the multi-stop color gradient block, bound to the top level
// depends on mscg_pkg and multi_stop_color_gradient_defines.svh
`include "multi_stop_color_gradient_defines.svh"

module mscg_checker
  import mscg_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic              m_axis_tlast,
  input logic              m_axis_tuser
);

  logic              in_take;
  logic              out_wait;
  logic [DATA_W:0]   out_word;

  // handshake shorthands
  assign in_take  = s_axis_tvalid && s_axis_tready;
  assign out_wait = m_axis_tvalid && !m_axis_tready;
  assign out_word = {m_axis_tlast, m_axis_tdata};

  // a stalled color holds its payload
  `MSCG_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_wait, m_axis_tvalid && $stable(out_word))

  // the gradient's final color also closes its run
  `MSCG_ASSERT_IMP(a_end_is_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tlast)

  // one stop at a time: ready drops right after a request is taken
  `MSCG_ASSERT_NXT(a_one_stop, clk_i, rst_ni, in_take, !s_axis_tready)

  // no color can appear in the cycle after a stop is taken
  `MSCG_ASSERT_NXT(a_no_early_out, clk_i, rst_ni, in_take, !$rose(m_axis_tvalid))

endmodule

bind multi_stop_color_gradient mscg_checker u_mscg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/tb_multi_stop_color_gradient.sv =====
`timescale 1ns / 1ps
// testbench for multi_stop_color_gradient: directed and random color stop requests
// depends on mscg_pkg and the gradient RTL; colors are predicted by an in-bench model
module tb_multi_stop_color_gradient;
  import mscg_pkg::*;

  localparam int unsigned MAX_COLORS    = 64;
  localparam int unsigned MAX_STEPS     = 63;
  localparam int unsigned SETTLE_CYCLES = 64;    // covers a stop that emits nothing
  localparam int unsigned QUIET_LIMIT   = 3000;  // cycles with no request moving
  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned PHASE_ITEMS   = 24;
  localparam int unsigned RANDOM_ITEMS  = 190;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            run_last;
    logic            grad_end;
  } grad_color_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = REG_COLOR_COUNT;
  logic [CFG_W-1:0]     cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata  = '0;  // in_red, in_green, in_blue
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;        // out_red, out_green, out_blue
  logic                 m_axis_tlast;        // run_last
  logic                 m_axis_tuser;        // gradient_end

  // gradient model state
  logic [CC_W-1:0]      mdl_grad_stops  = 7'd2;
  logic [SC_W-1:0]      mdl_stop_count  = 6'd2;
  logic [CH_W-1:0]      prev_red        = '0;
  logic [CH_W-1:0]      prev_green      = '0;
  logic [CH_W-1:0]      prev_blue       = '0;
  int unsigned          stops_taken     = 0;
  int unsigned          seg_steps       = 0;
  grad_color_t          pending_colors[$];
  grad_color_t          head_color;
  int unsigned          mismatch_count  = 0;
  int unsigned          quiet_cycles    = 0;

  // stall control
  bit                   tx_idle_en      = 1'b1;
  bit                   rx_idle_en      = 1'b1;
  int unsigned          hold_off_req    = 0;
  int unsigned          hold_off_seen   = 0;
  int unsigned          hold_off_left   = 0;

  multi_stop_color_gradient #(
    .MAX_COLORS(MAX_COLORS),
    .MAX_STEPS (MAX_STEPS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // rounded-half-up blend of one channel, exact integer form
  function automatic logic [CH_W-1:0] mix_channel(int unsigned a, int unsigned b,
                                                  int unsigned j, int unsigned n);
    int unsigned num;
    num = a * (n - j) + b * j;
    return CH_W'((2 * num + n) / (2 * n));
  endfunction

  // expected colors caused by one accepted stop
  function automatic void predict_gradient_colors(logic [DATA_W-1:0] stop);
    logic [CH_W-1:0] r, g, b;
    int unsigned     eff_colors, eff_stops, seen, j;
    bit              closing;
    grad_color_t     c;
    r = stop[CH_W-1:0];
    g = stop[2*CH_W-1:CH_W];
    b = stop[3*CH_W-1:2*CH_W];
    eff_colors = mdl_grad_stops;
    if (eff_colors < 2) eff_colors = 2;
    if (eff_colors > MAX_COLORS) eff_colors = MAX_COLORS;
    eff_stops = mdl_stop_count;
    if (eff_stops < 2) eff_stops = 2;
    if (eff_stops > MAX_STEPS) eff_stops = MAX_STEPS;
    // first stop of a gradient only latches N and the color
    if (stops_taken == 0) begin
      seg_steps   = (eff_stops / (eff_colors - 1)) % 64;
      prev_red    = r;
      prev_green  = g;
      prev_blue   = b;
      stops_taken = 1;
      return;
    end
    seen    = stops_taken + 1;
    closing = (seen >= eff_colors);
    for (j = 0; j < seg_steps; j++) begin
      c.red      = mix_channel(prev_red, r, j, seg_steps);
      c.green    = mix_channel(prev_green, g, j, seg_steps);
      c.blue     = mix_channel(prev_blue, b, j, seg_steps);
      c.run_last = !closing && (j + 1 == seg_steps);
      c.grad_end = 1'b0;
      pending_colors.push_back(c);
    end
    if (closing) begin
      c = '{red: r, green: g, blue: b, run_last: 1'b1, grad_end: 1'b1};
      pending_colors.push_back(c);
      stops_taken = 0;
      prev_red    = '0;
      prev_green  = '0;
      prev_blue   = '0;
    end else begin
      stops_taken = seen % 128;
      prev_red    = r;
      prev_green  = g;
      prev_blue   = b;
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare each emitted color, then track register writes and accepted stops
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_colors.size() == 0) begin
          $error("unexpected color: tdata %h, tlast %b, tuser %b",
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
          mismatch_count++;
        end else begin
          head_color = pending_colors.pop_front();
          check_field("out_red", head_color.red, m_axis_tdata[CH_W-1:0]);
          check_field("out_green", head_color.green, m_axis_tdata[2*CH_W-1:CH_W]);
          check_field("out_blue", head_color.blue, m_axis_tdata[3*CH_W-1:2*CH_W]);
          check_field("run_last", head_color.run_last, m_axis_tlast);
          check_field("gradient_end", head_color.grad_end, m_axis_tuser);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_COLOR_COUNT) mdl_grad_stops = cfg_wdata_i[CC_W-1:0];
        else if (cfg_idx_i == REG_STOP_COUNT) mdl_stop_count = cfg_wdata_i[SC_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) predict_gradient_colors(s_axis_tdata);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off_req != hold_off_seen) begin
      hold_off_seen <= hold_off_req;
      hold_off_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(99) < 30) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles where no request moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one stop after an optional random gap, return once accepted
  task automatic send_stop(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                           input logic [CH_W-1:0] b);
    int unsigned gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(99) < 30)
      gap = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(4, 1);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop offering, wait for every expected color and for the block to settle
  task automatic wait_gradient_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write both registers on back-to-back cycles
  task automatic set_config(input logic [CFG_W-1:0] colors, input logic [CFG_W-1:0] steps);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_COLOR_COUNT;
    cfg_wdata_i <= colors;
    @(posedge clk_i);
    cfg_idx_i   <= REG_STOP_COUNT;
    cfg_wdata_i <= steps;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [CH_W-1:0] pick_channel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom_range(255, 0));
    endcase
  endfunction

  // reset values of both registers: two-stop gradients with N of 2
  task automatic test_reset_registers();
    send_stop(8'h00, 8'h00, 8'h00);
    send_stop(8'hFF, 8'hFF, 8'hFF);
    send_stop(8'hFF, 8'hFF, 8'hFF);
    send_stop(8'h00, 8'h00, 8'h00);
    wait_gradient_idle();
  endtask

  // largest N and channel extremes with alternating bit patterns
  task automatic test_longest_segment();
    set_config(7'd2, 7'd63);
    send_stop(8'h55, 8'hAA, 8'h00);
    send_stop(8'hAA, 8'h55, 8'hFF);
    wait_gradient_idle();
    set_config(7'd3, 7'd63);
    send_stop(8'h00, 8'hFF, 8'h0F);
    send_stop(8'hFF, 8'h00, 8'hF0);
    send_stop(8'h80, 8'h7F, 8'h01);
    wait_gradient_idle();
  endtask

  // N of zero: inner stops emit nothing, the last one only itself
  task automatic test_zero_steps();
    set_config(7'd4, 7'd2);
    send_stop(8'h12, 8'h34, 8'h56);
    send_stop(8'hFE, 8'h01, 8'h80);
    send_stop(8'h7F, 8'hC3, 8'h3C);
    send_stop(8'hA5, 8'h5A, 8'hFF);
    wait_gradient_idle();
  endtask

  // counts below the range saturate up, stop_count drops its top bit
  task automatic test_range_saturation();
    set_config(7'd0, 7'h41);
    send_stop(8'h10, 8'h20, 8'h30);
    send_stop(8'hF0, 8'hE0, 8'hD0);
    wait_gradient_idle();
    set_config(7'd1, 7'd0);
    send_stop(8'h01, 8'hFE, 8'h02);
    send_stop(8'hFD, 8'h03, 8'hFC);
    wait_gradient_idle();
  endtask

  // counts above the range saturate down or, for stop_count, lose the top bit; a later change ends the gradient early
  task automatic test_config_mid_gradient();
    set_config(7'h7F, 7'h7F);
    send_stop(8'h00, 8'h80, 8'hFF);
    send_stop(8'hFF, 8'h81, 8'h00);
    wait_gradient_idle();
    // N stays latched at 1, the third stop now closes the gradient
    set_config(7'd3, 7'd20);
    send_stop(8'h40, 8'hC0, 8'h20);
    wait_gradient_idle();
  endtask

  // receiver holds off while the sender keeps offering stops
  task automatic test_output_backpressure();
    set_config(7'd2, 7'd40);
    hold_off_req <= hold_off_req + 1;
    send_stop(8'h00, 8'h11, 8'h22);
    send_stop(8'hFF, 8'hEE, 8'hDD);
    send_stop(8'h33, 8'h44, 8'h55);
    send_stop(8'hCC, 8'hBB, 8'hAA);
    wait_gradient_idle();
  endtask

  // random phases of random settings and stops; one phase without any stalls
  task automatic test_random_gradients();
    int unsigned      sent, phase, k;
    logic [CFG_W-1:0] colors, steps;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_gradient_idle();
      case ($urandom_range(9))
        0:       colors = CFG_W'($urandom_range(1, 0));
        1:       colors = CFG_W'($urandom_range(127, 65));
        2:       colors = 7'd64;
        default: colors = CFG_W'($urandom_range(6, 2));
      endcase
      case ($urandom_range(5))
        0:       steps = 7'd63;
        1:       steps = CFG_W'($urandom_range(1, 0));
        default: steps = CFG_W'($urandom_range(127, 0));
      endcase
      set_config(colors, steps);
      tx_idle_en  = (phase != 3);
      rx_idle_en <= (phase != 3);
      for (k = 0; k < PHASE_ITEMS; k++) send_stop(pick_channel(), pick_channel(), pick_channel());
      sent += PHASE_ITEMS;
      phase++;
    end
    tx_idle_en  = 1'b1;
    rx_idle_en <= 1'b1;
  endtask

  // test sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_registers();
    test_longest_segment();
    test_zero_steps();
    test_range_saturation();
    test_config_mid_gradient();
    test_output_backpressure();
    test_random_gradients();
    wait_gradient_idle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
